@@ sv/ps2mct_pkg.sv @@
`timescale 1ns / 1ps

package ps2mct_pkg;

  // Configuration register indexes
  localparam logic [1:0] RegThresholdX = 2'd0;
  localparam logic [1:0] RegThresholdY = 2'd1;
  localparam logic [1:0] RegScreenCols = 2'd2;
  localparam logic [1:0] RegScreenRows = 2'd3;

  // Configuration reset values
  localparam logic [7:0] ThresholdReset = 8'd4;
  localparam logic [7:0] ColsReset      = 8'd80;
  localparam logic [7:0] RowsReset      = 8'd25;

  // Cursor start position: screen center
  localparam logic [7:0] CursorXReset = 8'd40;
  localparam logic [7:0] CursorYReset = 8'd12;

  // Terminal select codes
  localparam logic [1:0] SelNone   = 2'd0;
  localparam logic [1:0] SelLeft   = 2'd1;
  localparam logic [1:0] SelMiddle = 2'd2;
  localparam logic [1:0] SelRight  = 2'd3;

  // Packet byte positions
  localparam logic [1:0] ByteHeader = 2'd0;
  localparam logic [1:0] ByteX      = 2'd1;
  localparam logic [1:0] ByteY      = 2'd2;

  // Header bit positions
  localparam int unsigned HdrLeft  = 0;
  localparam int unsigned HdrRight = 1;
  localparam int unsigned HdrMid   = 2;
  localparam int unsigned HdrSignX = 4;
  localparam int unsigned HdrSignY = 5;
  localparam int unsigned HdrOvfX  = 6;
  localparam int unsigned HdrOvfY  = 7;

  // Quantize a 9-bit signed delta (sign flag + data byte) to -2..2.
  function automatic logic signed [2:0] quantize(input logic negative,
                                                 input logic [7:0] data,
                                                 input logic [7:0] thr);
    logic [8:0] mag;
    logic [1:0] step;
    mag = negative ? (9'd256 - {1'b0, data}) : {1'b0, data};
    if (mag == 9'd0) begin
      step = 2'd0;
    end else if (mag <= {1'b0, thr}) begin
      step = 2'd1;
    end else begin
      step = 2'd2;
    end
    quantize = negative ? -$signed({1'b0, step}) : $signed({1'b0, step});
  endfunction

  // Move a coordinate by a step and clamp to [0, size-1]; size 0 acts as 1.
  function automatic logic [7:0] move_clamped(input logic [7:0] pos,
                                              input logic signed [2:0] step,
                                              input logic [7:0] size);
    logic signed [9:0] lim;
    logic signed [9:0] p;
    lim = (size == 8'd0) ? 10'sd0 : $signed({2'b00, size}) - 10'sd1;
    p   = $signed({2'b00, pos}) + 10'(step);
    if (p > lim) begin
      p = lim;
    end
    if (p < 10'sd0) begin
      p = 10'sd0;
    end
    move_clamped = p[7:0];
  endfunction

endpackage

@@ sv/ps2_mouse_packet_cursor_tracker_core.sv @@
`timescale 1ns / 1ps

// PS/2 mouse packet decoder and text cursor tracker. One mouse byte is taken
// per cycle; every third byte closes a packet (header, x delta, y delta). A
// packet with either overflow bit set is dropped; otherwise its deltas are
// quantized to 0, +/-1 or +/-2 against threshold_x / threshold_y and move the
// cursor, clamped to screen_cols x screen_rows (a size of 0 holds that
// coordinate at 0). Upward motion lowers the row. Each accepted packet gives
// one result: column, row, new cell index (row * screen_cols + column,
// 16 bits), the previous result's cell index, and the terminal select (left
// over right over middle). After a packet's last byte is transferred, the
// cursor update is registered first, then the cell multiply, which makes the
// result valid. Input is taken every cycle unless both the cursor stage and
// the output register hold results that the sink has not yet taken. Write the
// configuration only while no packet is in flight.
module ps2_mouse_packet_cursor_tracker_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] cursor_col_o,
  output logic [7:0] cursor_row_o,
  output logic [15:0] new_cell_o,
  output logic [15:0] prior_cell_o,
  output logic [1:0] term_select_o
);
  import ps2mct_pkg::*;

  logic [7:0] thr_x_q, thr_y_q, cols_q, rows_q;
  logic [1:0] byte_cnt_q, byte_cnt_d;
  logic [7:0] header_q, xbyte_q;
  logic [7:0] cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  logic       s1_valid_q, s1_valid_d;
  logic [1:0] s1_sel_q, s1_sel_d;
  logic       out_valid_q;
  logic [7:0] out_col_q, out_row_q;
  logic [15:0] out_new_q, out_prior_q, last_cell_q;
  logic [1:0] out_sel_q;

  logic              in_xfer, out_adv, s1_load, s1_adv, overflow;
  logic signed [2:0] step_x, step_y;
  logic [15:0]       cell_idx;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_x_q <= ThresholdReset;
      thr_y_q <= ThresholdReset;
      cols_q  <= ColsReset;
      rows_q  <= RowsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegThresholdX: thr_x_q <= cfg_wdata_i;
        RegThresholdY: thr_y_q <= cfg_wdata_i;
        RegScreenCols: cols_q  <= cfg_wdata_i;
        RegScreenRows: rows_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_adv;
  // Hold input only while the cursor stage is full and cannot drain
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign overflow = header_q[HdrOvfX] || header_q[HdrOvfY];
  assign step_x   = quantize(header_q[HdrSignX], xbyte_q, thr_x_q);
  assign step_y   = quantize(header_q[HdrSignY], data_byte_i, thr_y_q);

  always_comb begin
    byte_cnt_d = byte_cnt_q;
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    s1_load    = 1'b0;
    s1_sel_d   = s1_sel_q;
    s1_valid_d = s1_valid_q && !out_adv;
    if (in_xfer) begin
      unique case (byte_cnt_q)
        ByteHeader: byte_cnt_d = ByteX;
        ByteX:      byte_cnt_d = ByteY;
        default: begin
          byte_cnt_d = ByteHeader;
          if (!overflow) begin
            s1_load    = 1'b1;
            s1_valid_d = 1'b1;
            cursor_x_d = move_clamped(cursor_x_q, step_x, cols_q);
            cursor_y_d = move_clamped(cursor_y_q, -step_y, rows_q);
            priority if (header_q[HdrLeft]) begin
              s1_sel_d = SelLeft;
            end else if (header_q[HdrRight]) begin
              s1_sel_d = SelRight;
            end else if (header_q[HdrMid]) begin
              s1_sel_d = SelMiddle;
            end else begin
              s1_sel_d = SelNone;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= ByteHeader;
      header_q   <= '0;
      xbyte_q    <= '0;
      cursor_x_q <= CursorXReset;
      cursor_y_q <= CursorYReset;
      s1_valid_q <= 1'b0;
    end else begin
      byte_cnt_q <= byte_cnt_d;
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      s1_valid_q <= s1_valid_d;
      if (in_xfer && byte_cnt_q == ByteHeader) begin
        header_q <= data_byte_i;
      end
      if (in_xfer && byte_cnt_q == ByteX) begin
        xbyte_q <= data_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sel_q <= s1_sel_d;
  end

  // Cell index from the registered cursor
  assign cell_idx = 16'(cursor_y_q * cols_q) + {8'd0, cursor_x_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_cell_q <= '0;
    end else begin
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        last_cell_q <= cell_idx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_col_q   <= cursor_x_q;
      out_row_q   <= cursor_y_q;
      out_new_q   <= cell_idx;
      out_prior_q <= last_cell_q;
      out_sel_q   <= s1_sel_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cursor_col_o  = out_col_q;
  assign cursor_row_o  = out_row_q;
  assign new_cell_o    = out_new_q;
  assign prior_cell_o  = out_prior_q;
  assign term_select_o = out_sel_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_cnt_q <= ByteY)
    else $error("byte count out of range");

  a_load_on_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_load |-> (byte_cnt_q == ByteY && !overflow))
    else $error("cursor stage loaded outside a packet end");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input held without a full pipeline");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("result did not reach the output register");

  a_prior_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (prior_cell_o == $past(last_cell_q) && last_cell_q == new_cell_o))
    else $error("prior cell chain broken");
`endif

endmodule
